### design/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared constants, codes and cell command types for the ordered list table.
// ----------------------------------------------------------------------------
`default_nettype none

package olt_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int FIELD_W  = 32;
    localparam int OPCODE_W = 4;
    localparam int POSIN_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = (CNT_W > POSIN_W) ? CNT_W : POSIN_W;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 4'd0,
        OP_PUSH_BACK  = 4'd1,
        OP_POP_FRONT  = 4'd2,
        OP_POP_BACK   = 4'd3,
        OP_INSERT_UNQ = 4'd4,
        OP_REMOVE     = 4'd5,
        OP_READ       = 4'd6,
        OP_WRITE      = 4'd7,
        OP_CLEAR      = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_REMOVE,
        CELL_LOAD
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_data    value;
        t_pos     load_sel;
        t_pos     rd_sel;
        t_pos     back_sel;
        t_pos     count;
    } t_cell_cmd;

    typedef struct packed {
        logic  hit;
        t_data rd;
        t_data back;
    } t_chain;

    function automatic t_data field_to_data(input logic [FIELD_W-1:0] v);
        t_data d;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            d[i] = (i < FIELD_W) ? v[i] : 1'b0;
        end
        return d;
    endfunction

    function automatic logic [FIELD_W-1:0] data_to_field(input t_data d);
        logic [FIELD_W-1:0] v;
        for (int i = 0; i < FIELD_W; i++) begin
            v[i] = (i < DATA_WIDTH) ? d[i] : 1'b0;
        end
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] cnt_to_field(input t_cnt c);
        logic [COUNT_W-1:0] v;
        for (int i = 0; i < COUNT_W; i++) begin
            v[i] = (i < CNT_W) ? c[i] : 1'b0;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### design/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell
// One slot of the list: holds a word, shifts toward either neighbor, loads on
// a selected index, and extends the match, read and back chains.
// ----------------------------------------------------------------------------
`default_nettype none

module olt_cell (
    input  wire logic               i_clk,
    input  wire olt_pkg::t_cell_cmd i_cmd,
    input  wire olt_pkg::t_pos      i_idx,
    input  wire olt_pkg::t_data     i_left,
    input  wire olt_pkg::t_data     i_right,
    input  wire olt_pkg::t_chain    i_chain,
    output olt_pkg::t_data          o_data,
    output olt_pkg::t_data          o_next,
    output olt_pkg::t_chain         o_chain
);
    import olt_pkg::*;

    t_data r_data;
    t_data n_data;
    logic  w_live;
    logic  w_match;
    logic  w_after;

    assign w_live  = i_idx < i_cmd.count;
    assign w_match = w_live && (r_data == i_cmd.value);
    assign w_after = i_chain.hit | w_match;

    always_comb begin
        case (i_cmd.op)
            CELL_HOLD:       n_data = r_data;
            CELL_TAKE_LEFT:  n_data = i_left;
            CELL_TAKE_RIGHT: n_data = i_right;
            CELL_REMOVE:     n_data = w_after ? i_right : r_data;
            CELL_LOAD:       n_data = (i_idx == i_cmd.load_sel) ? i_cmd.value : r_data;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data       = r_data;
    assign o_next       = n_data;
    assign o_chain.hit  = w_after;
    assign o_chain.rd   = i_chain.rd | ((i_idx == i_cmd.rd_sel) ? r_data : '0);
    assign o_chain.back = i_chain.back | ((i_idx == i_cmd.back_sel) ? n_data : '0);

endmodule

`default_nettype wire

### design/ordered_list_table.sv
// ----------------------------------------------------------------------------
// ordered_list_table
// Bounded ordered list with front/back push and pop, search, indexed access.
//
// Input channel (i_valid/o_ready) carries one operation word: opcode, value,
// position. Output channel (o_valid/i_ready) returns one result word per
// operation: status, done flag, read value, count, front and back values.
// Storage is a row of cells, one per slot, each shifting toward a neighbor
// in the same cycle, so every operation finishes in the cycle it is taken.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one operation per cycle while results are taken; the search is
// a match chain through all cells in that cycle.
// A result waiting in the output register holds while i_ready is low; a
// new word is taken only in a cycle where that result leaves or none waits.
// Reset empties the list and drops any pending result; slot contents are
// not cleared and are never shown until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [olt_pkg::OPCODE_W-1:0]  i_opcode,
    input  wire logic [olt_pkg::FIELD_W-1:0]   i_value,
    input  wire logic [olt_pkg::POSIN_W-1:0]   i_position,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_status,
    output logic                               o_done_res,
    output logic [olt_pkg::FIELD_W-1:0]        o_read_value,
    output logic [olt_pkg::COUNT_W-1:0]        o_count,
    output logic [olt_pkg::FIELD_W-1:0]        o_front_value,
    output logic [olt_pkg::FIELD_W-1:0]        o_back_value
);
    import olt_pkg::*;

    t_cnt      r_count;
    t_cnt      n_count;
    logic      r_valid;
    t_status   r_status;
    logic      r_done;
    t_data     r_read;
    t_data     r_front;
    t_data     r_back;

    t_cell_cmd w_cmd;
    t_status   w_status;
    logic      w_done;
    logic      w_rd_ok;
    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    logic      w_pos_ok;
    logic      w_hit;
    t_data     w_value;
    t_pos      w_pos;
    t_pos      w_cnt_pos;

    t_data     w_data  [CAPACITY];
    t_data     w_next  [CAPACITY];
    t_chain    w_chain [CAPACITY+1];

    assign o_ready   = !r_valid || i_ready;
    assign w_accept  = i_valid && o_ready;
    assign w_value   = field_to_data(i_value);
    assign w_pos     = POS_W'(i_position);
    assign w_cnt_pos = POS_W'(r_count);
    assign w_full    = r_count == CNT_W'(CAPACITY);
    assign w_empty   = r_count == '0;
    assign w_pos_ok  = w_pos < w_cnt_pos;
    assign w_hit     = w_chain[CAPACITY].hit;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        olt_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (POS_W'(g)),
            .i_left  ((g == 0) ? w_value : w_data[(g == 0) ? 0 : g-1]),
            .i_right ((g == CAPACITY-1) ? '0 : w_data[(g == CAPACITY-1) ? g : g+1]),
            .i_chain (w_chain[g]),
            .o_data  (w_data[g]),
            .o_next  (w_next[g]),
            .o_chain (w_chain[g+1])
        );
    end

    always_comb begin
        w_cmd.op       = CELL_HOLD;
        w_cmd.value    = w_value;
        w_cmd.load_sel = w_cnt_pos;
        w_cmd.rd_sel   = w_pos;
        w_cmd.count    = w_cnt_pos;
        w_status       = ST_OK;
        w_done         = 1'b0;
        w_rd_ok        = 1'b0;
        n_count        = r_count;
        case (t_op'(i_opcode))
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.op = CELL_TAKE_LEFT;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.op = CELL_LOAD;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                w_cmd.rd_sel = '0;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.op = CELL_TAKE_RIGHT;
                    w_rd_ok  = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_INSERT_UNQ: begin
                if (!w_hit) begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_cmd.op = CELL_LOAD;
                        w_done   = 1'b1;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
            end
            OP_REMOVE: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_hit) begin
                    w_cmd.op = CELL_REMOVE;
                    w_done   = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_status = ST_RANGE;
                end else begin
                    w_rd_ok = 1'b1;
                end
            end
            OP_WRITE: begin
                w_cmd.load_sel = w_pos;
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.op = CELL_LOAD;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!w_accept) begin
            w_cmd.op = CELL_HOLD;
            n_count  = r_count;
        end
        w_cmd.back_sel = POS_W'(n_count) - POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_done   <= w_done;
            r_read   <= w_rd_ok ? w_chain[CAPACITY].rd : '0;
            r_front  <= (n_count != '0) ? w_next[0] : '0;
            r_back   <= (n_count != '0) ? w_chain[CAPACITY].back : '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_done_res    = r_done;
    assign o_read_value  = data_to_field(r_read);
    assign o_count       = cnt_to_field(r_count);
    assign o_front_value = data_to_field(r_front);
    assign o_back_value  = data_to_field(r_back);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count == '0) |-> (o_front_value == '0 && o_back_value == '0))
        else $error("empty list shows nonzero front or back");

    a_err_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> !o_done_res)
        else $error("done flag set on failed operation");

    a_push_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode == OP_PUSH_FRONT && !w_full)
        |=> (o_front_value == data_to_field(field_to_data($past(i_value)))))
        else $error("pushed word not at front");
`endif

endmodule

`default_nettype wire
